// File: src/sme_pkg.sv
// Package for the stack machine execute unit: opcodes, fault codes, FSM states.
// No dependencies.
`timescale 1ns / 1ps
package sme_pkg;

  typedef enum logic [3:0] {
    OP_PRINT = 4'd0, OP_DUP = 4'd1, OP_PUSH = 4'd2, OP_ADD = 4'd3,
    OP_SUB = 4'd4, OP_MUL = 4'd5, OP_DIV = 4'd6, OP_MOD = 4'd7,
    OP_LESS = 4'd8, OP_IF = 4'd9, OP_JUMP = 4'd10, OP_JUMPF = 4'd11,
    OP_CALL = 4'd12, OP_HALT = 4'd13, OP_ILL0 = 4'd14, OP_ILL1 = 4'd15
  } opcode_e;

  typedef enum logic [2:0] {
    FLT_NONE = 3'd0, FLT_UNDER = 3'd1, FLT_OVER = 3'd2,
    FLT_DIVZ = 3'd3, FLT_ILLEGAL = 3'd4
  } fault_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RD0, ST_RD1, ST_EXEC, ST_DIV, ST_DONE
  } state_e;

endpackage

// File: src/sme_if.sv
// Valid/ready channel interfaces for instruction and result words.
// Depends on nothing.
`timescale 1ns / 1ps
interface sme_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  opcode;
  logic signed [31:0] operand;
  modport source (output valid, opcode, operand, input ready);
  modport sink   (input valid, opcode, operand, output ready);
endinterface

interface sme_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  words_used;
  logic signed [31:0] pc_adjust;
  logic        print_valid;
  logic signed [31:0] print_value;
  logic        call_valid;
  logic [7:0]  call_index;
  logic        halted;
  logic [2:0]  fault;
  modport source (output valid, words_used, pc_adjust, print_valid, print_value,
                  call_valid, call_index, halted, fault, input ready);
  modport sink   (input valid, words_used, pc_adjust, print_valid, print_value,
                  call_valid, call_index, halted, fault, output ready);
endinterface

// File: src/stack_machine_execute_unit.sv
// Top level of the stack machine execute unit: stack RAM, sequencer, serial divider.
// Depends on sme_pkg and the channel interfaces in sme_if.sv.
`timescale 1ns / 1ps
// One instruction word is taken at a time. Every instruction reads the top two
// stack entries from the stack RAM in successive cycles (one read per cycle,
// registered data) and writes back at most once. The word passes through ST_RD0,
// ST_RD1, ST_EXEC and ST_DONE; its result is registered on leaving ST_DONE, when
// the next word can be accepted. Div and mod without a fault also pass through
// ST_DIV, the one-bit-per-cycle restoring divider. The result sits in an output
// register; a new instruction runs while it waits, but cannot finish until taken.
module stack_machine_execute_unit import sme_pkg::*; #(
  parameter int STACK_DEPTH = 32,
  parameter int WORD_WIDTH  = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  sme_in_if.sink    in_i,
  sme_out_if.source out_o
);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int DW = $clog2(WORD_WIDTH + 1);
  localparam logic [WORD_WIDTH-1:0] WSIGN = {1'b1, {(WORD_WIDTH-1){1'b0}}};

  logic [WORD_WIDTH-1:0] mem [STACK_DEPTH];
  logic [WORD_WIDTH-1:0] rdata_q;
  logic [AW-1:0] raddr, waddr;
  logic [WORD_WIDTH-1:0] wdata;
  logic we;

  state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  opcode_e op_q;
  logic [31:0] imm_q;
  logic [WORD_WIDTH-1:0] r_q, l_q, r_d, l_d;
  // divider
  logic [WORD_WIDTH-1:0] dq_q, dq_d, drem_q, drem_d, dmr_q, dmr_d;
  logic [DW-1:0] dcnt_q, dcnt_d;
  logic [WORD_WIDTH:0] trial;
  // output register
  logic ov_q, ov_d;
  logic [1:0] wu_q, wu_d;
  logic [31:0] adj_q, adj_d, pval_q, pval_d;
  logic pv_q, pv_d, cv_q, cv_d, hl_q, hl_d;
  logic [7:0] ci_q, ci_d;
  fault_e flt_q, flt_d;
  logic [WORD_WIDTH-1:0] res, imm_w, ml, mr;
  logic [2*WORD_WIDTH-1:0] prod;
  logic [CW-1:0] ncnt;

  assign in_i.ready = (state_q == ST_IDLE);
  assign imm_w = WORD_WIDTH'(signed'(imm_q));
  assign prod  = l_q * r_q;
  assign ml = l_q[WORD_WIDTH-1] ? -l_q : l_q;
  assign mr = r_q[WORD_WIDTH-1] ? -r_q : r_q;
  assign trial = {drem_q, dq_q[WORD_WIDTH-1]} - {1'b0, dmr_q};

  // stack RAM, registered read
  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      op_q  <= opcode_e'(in_i.opcode);
      imm_q <= in_i.operand;
    end
    r_q <= r_d; l_q <= l_d;
    dq_q <= dq_d; drem_q <= drem_d; dmr_q <= dmr_d; dcnt_q <= dcnt_d;
    wu_q <= wu_d; adj_q <= adj_d; pv_q <= pv_d; pval_q <= pval_d;
    cv_q <= cv_d; ci_q <= ci_d; hl_q <= hl_d; flt_q <= flt_d;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_i.valid) state_d = ST_RD0;
      ST_RD0:  state_d = ST_RD1;
      ST_RD1:  state_d = ST_EXEC;
      ST_EXEC: begin
        if ((op_q == OP_DIV || op_q == OP_MOD) && cnt_q >= CW'(2) && r_q != '0)
          state_d = ST_DIV;
        else state_d = ST_DONE;
      end
      ST_DIV:  if (dcnt_q == DW'(1)) state_d = ST_DONE;
      ST_DONE: if (!ov_q || out_o.ready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    raddr = '0; waddr = AW'(cnt_q); wdata = '0; we = 1'b0;
    cnt_d = cnt_q; r_d = r_q; l_d = l_q; res = '0; ncnt = cnt_q;
    dq_d = dq_q; drem_d = drem_q; dmr_d = dmr_q; dcnt_d = dcnt_q;
    ov_d = ov_q; wu_d = wu_q; adj_d = adj_q; pv_d = pv_q; pval_d = pval_q;
    cv_d = cv_q; ci_d = ci_q; hl_d = hl_q; flt_d = flt_q;
    if (ov_q && out_o.ready) ov_d = 1'b0;
    unique case (state_q)
      ST_IDLE: raddr = AW'(cnt_q - CW'(1));
      ST_RD0: begin
        raddr = AW'(cnt_q - CW'(2));
        r_d = rdata_q;
      end
      ST_RD1:  l_d = rdata_q;
      ST_EXEC: begin
        // preload divider with magnitudes
        dq_d   = ml;
        drem_d = '0;
        dmr_d  = mr;
        dcnt_d = DW'(WORD_WIDTH);
      end
      ST_DIV: begin
        if (!trial[WORD_WIDTH]) begin
          drem_d = trial[WORD_WIDTH-1:0];
          dq_d   = {dq_q[WORD_WIDTH-2:0], 1'b1};
        end else begin
          drem_d = {drem_q[WORD_WIDTH-2:0], dq_q[WORD_WIDTH-1]};
          dq_d   = {dq_q[WORD_WIDTH-2:0], 1'b0};
        end
        dcnt_d = dcnt_q - DW'(1);
      end
      ST_DONE: begin
        if (!ov_q || out_o.ready) begin
          ov_d = 1'b1;
          wu_d = (op_q == OP_PUSH || op_q == OP_JUMP || op_q == OP_JUMPF ||
                  op_q == OP_CALL) ? 2'd2 : 2'd1;
          adj_d = '0; pv_d = 1'b0; pval_d = '0; cv_d = 1'b0; ci_d = '0;
          hl_d = 1'b0; flt_d = FLT_NONE;
          case (op_q)
            OP_PRINT: if (cnt_q < CW'(1)) flt_d = FLT_UNDER;
              else begin
                pv_d = 1'b1; pval_d = 32'(signed'(r_q)); ncnt = cnt_q - CW'(1);
              end
            OP_DUP: if (cnt_q < CW'(1)) flt_d = FLT_UNDER;
              else if (cnt_q >= CW'(STACK_DEPTH)) flt_d = FLT_OVER;
              else begin
                we = 1'b1; wdata = r_q; ncnt = cnt_q + CW'(1);
              end
            OP_PUSH: if (cnt_q >= CW'(STACK_DEPTH)) flt_d = FLT_OVER;
              else begin
                we = 1'b1; wdata = imm_w; ncnt = cnt_q + CW'(1);
              end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_LESS: begin
              if (cnt_q < CW'(2)) flt_d = FLT_UNDER;
              else if ((op_q == OP_DIV || op_q == OP_MOD) && r_q == '0)
                flt_d = FLT_DIVZ;
              else begin
                case (op_q)
                  OP_ADD:  res = l_q + r_q;
                  OP_SUB:  res = l_q - r_q;
                  OP_MUL:  res = prod[WORD_WIDTH-1:0];
                  OP_LESS: res = WORD_WIDTH'((l_q ^ WSIGN) < (r_q ^ WSIGN));
                  OP_DIV:  res = ((l_q ^ r_q) & WSIGN) != '0 ? -dq_q : dq_q;
                  default: res = l_q[WORD_WIDTH-1] ? -drem_q : drem_q;
                endcase
                we = 1'b1; wdata = res; waddr = AW'(cnt_q - CW'(2));
                ncnt = cnt_q - CW'(1);
              end
            end
            OP_IF: if (cnt_q < CW'(1)) flt_d = FLT_UNDER;
              else begin
                if (r_q != '0) adj_d = 32'd2;
                ncnt = cnt_q - CW'(1);
              end
            OP_JUMP: adj_d = imm_q;
            OP_JUMPF: if (cnt_q < CW'(1)) flt_d = FLT_UNDER;
              else begin
                if (r_q == '0) adj_d = imm_q;
                ncnt = cnt_q - CW'(1);
              end
            OP_CALL: begin cv_d = 1'b1; ci_d = imm_q[7:0]; end
            OP_HALT: hl_d = 1'b1;
            default: flt_d = FLT_ILLEGAL;
          endcase
          cnt_d = ncnt;
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid       = ov_q;
  assign out_o.words_used  = wu_q;
  assign out_o.pc_adjust   = adj_q;
  assign out_o.print_valid = pv_q;
  assign out_o.print_value = pval_q;
  assign out_o.call_valid  = cv_q;
  assign out_o.call_index  = ci_q;
  assign out_o.halted      = hl_q;
  assign out_o.fault       = flt_q;
endmodule

// File: src/sme_checker.sv
// Port-level checks for the stack machine execute unit, bound to the top level.
// Depends on sme_pkg.
`timescale 1ns / 1ps
module sme_checker import sme_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid, in_ready,
  input logic out_valid, out_ready,
  input logic print_valid, call_valid, halted,
  input logic [2:0] fault,
  input logic [1:0] words_used
);
  // a faulting word reports no side effects
  a_fault_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && fault != FLT_NONE |-> !print_valid && !call_valid && !halted)
    else $error("fault with side effect");
  // at most one side effect per word
  a_one_effect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> $onehot0({print_valid, call_valid, halted}))
    else $error("multiple effects");
  // one instruction in flight: no accept the cycle after an accept
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("overlapping accepts");
  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(words_used))
    else $error("result dropped");
endmodule

bind stack_machine_execute_unit sme_checker u_sme_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid(in_i.valid), .in_ready(in_i.ready),
  .out_valid(out_o.valid), .out_ready(out_o.ready),
  .print_valid(out_o.print_valid), .call_valid(out_o.call_valid),
  .halted(out_o.halted), .fault(out_o.fault), .words_used(out_o.words_used)
);
